/* rtl/kvc_pkg.sv */
// Shared types and constants for the key velocity curve unit.
`timescale 1ns / 1ps
package kvc_pkg;

    // Field widths of the event and result words
    localparam int TICK_W    = 16;
    localparam int NOTE_W    = 7;
    localparam int VEL_W     = 7;

    // Coefficient register widths (scale, offset and base are Q.8 signed)
    localparam int SCALE_W   = 32;
    localparam int OFFSET_W  = 24;
    localparam int BASE_W    = 16;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;

    // Datapath widths: d = t*256 + b, num = 256*a + c*d, den = 256*d
    localparam int D_W       = 26;
    localparam int PROD_W    = BASE_W + D_W;
    localparam int NUM_W     = PROD_W + 1;
    localparam int DEN_W     = D_W + 8;
    localparam int CMP_W     = DEN_W + 17;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Octave pattern, a set bit marks a black key
    localparam int              OCTAVE      = 12;
    localparam int              NOTE_COUNT  = 128;
    localparam logic [OCTAVE-1:0] KEY_PATTERN = 12'b010101001010;

    function automatic logic [NOTE_COUNT-1:0] build_black_map();
        logic [NOTE_COUNT-1:0] m;
        m = '0;
        for (int i = 0; i < NOTE_COUNT; i++) begin
            m[i] = KEY_PATTERN[i % OCTAVE];
        end
        return m;
    endfunction

    localparam logic [NOTE_COUNT-1:0] BLACK_MAP = build_black_map();

    // Coefficient register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WHITE_SCALE  = 3'd0,
        CFG_WHITE_OFFSET = 3'd1,
        CFG_WHITE_BASE   = 3'd2,
        CFG_BLACK_SCALE  = 3'd3,
        CFG_BLACK_OFFSET = 3'd4,
        CFG_BLACK_BASE   = 3'd5
    } t_cfg_index;

    // Key event mode
    localparam logic MODE_PRESS   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    // Input word
    typedef struct packed {
        logic              mode;
        logic [NOTE_W-1:0] note_number;
        logic [TICK_W-1:0] tick_count;
    } t_key_event;

    // Result word
    typedef struct packed {
        logic [VEL_W-1:0] velocity;
        logic             is_black;
        logic             clamped;
    } t_key_velocity;

    // Classified job passed from front to back
    typedef struct packed {
        logic                       mode;
        logic                       is_black;
        logic                       zero_div;
        logic signed [SCALE_W-1:0]  a;
        logic signed [BASE_W-1:0]   c;
        logic signed [D_W-1:0]      d;
        logic        [TICK_W-1:0]   t;
    } t_job;

endpackage

/* rtl/key_velocity_curve_unit.sv */
// Top level of the key velocity curve unit.
//
// Takes one key event word (mode, note number, tick count) and returns one
// velocity word (velocity, is_black, clamped) per event, in order.
// Input and output channels use valid/stall; a word moves on a clock edge
// with valid high and stall low. The coefficient registers (A, B, C for
// white and black keys) are written through a plain write port by index.
// The front part looks up the key color, selects coefficients and forms
// the divisor, then pushes a job into a 4-entry queue. The back part builds
// the numerator, divides in a restoring divider unrolled one quotient bit
// per stage, clamps and registers the result.
// Throughput: one word per cycle while the output is not stalled.
// Reset (i_rst_n low, synchronous) clears the coefficients to zero and
// empties the queue and pipeline. A stalled output holds its word and
// freezes the back pipeline; input stall rises only when the queue is full.
`timescale 1ns / 1ps
module key_velocity_curve_unit #(
    parameter int MAX_VELOCITY = 127,
    parameter int TICK_WIDTH   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [kvc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kvc_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  kvc_pkg::t_key_event            i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output kvc_pkg::t_key_velocity         o_out_word
);
    import kvc_pkg::*;

    localparam int JOB_W = $bits(t_job);

    t_job w_job_in, w_job_out;
    logic w_push, w_full, w_pop, w_job_valid;

    kvc_front #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .i_queue_full (w_full),
        .o_job_push   (w_push),
        .o_job        (w_job_in)
    );

    kvc_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rdata (w_job_out),
        .o_valid (w_job_valid)
    );

    kvc_back #(
        .MAX_VELOCITY (MAX_VELOCITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job_out),
        .i_job_valid (w_job_valid),
        .o_job_pop   (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

/* rtl/kvc_fifo.sv */
// Small register queue between the front and back parts.
`timescale 1ns / 1ps
module kvc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_valid
);
    // DEPTH must be a power of two so the pointers wrap on their own
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [AW:0]      r_count;
    logic             n_push, n_pop;

    assign n_push  = i_push && !o_full;
    assign n_pop   = i_pop && o_valid;
    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd_ptr];

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (n_push) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (n_pop)  r_rd_ptr <= r_rd_ptr + 1'b1;
            case ({n_push, n_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (n_push) r_mem[r_wr_ptr] <= i_wdata;
    end

endmodule

/* rtl/kvc_front.sv */
// Front part: coefficient registers, key color lookup and divisor setup.
`timescale 1ns / 1ps
module kvc_front #(
    parameter int TICK_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [kvc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kvc_pkg::CFG_W-1:0]      i_cfg_wdata,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  kvc_pkg::t_key_event            i_in_word,
    input  logic                           i_queue_full,
    output logic                           o_job_push,
    output kvc_pkg::t_job                  o_job
);
    import kvc_pkg::*;

    // Ticks are taken modulo 2^TICK_WIDTH
    localparam int TW_EFF = (TICK_WIDTH < TICK_W) ? TICK_WIDTH : TICK_W;
    localparam logic [TICK_W-1:0] TICK_MASK = TICK_W'((33'd1 << TW_EFF) - 33'd1);

    logic signed [SCALE_W-1:0]  r_white_scale, r_black_scale;
    logic signed [OFFSET_W-1:0] r_white_offset, r_black_offset;
    logic signed [BASE_W-1:0]   r_white_base, r_black_base;

    logic                       n_black;
    logic [TICK_W-1:0]          n_t;
    logic signed [OFFSET_W-1:0] n_b;
    logic signed [D_W-1:0]      n_d;

    // Coefficient register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white_scale  <= '0;
            r_white_offset <= '0;
            r_white_base   <= '0;
            r_black_scale  <= '0;
            r_black_offset <= '0;
            r_black_base   <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_WHITE_SCALE:  r_white_scale  <= i_cfg_wdata[SCALE_W-1:0];
                CFG_WHITE_OFFSET: r_white_offset <= i_cfg_wdata[OFFSET_W-1:0];
                CFG_WHITE_BASE:   r_white_base   <= i_cfg_wdata[BASE_W-1:0];
                CFG_BLACK_SCALE:  r_black_scale  <= i_cfg_wdata[SCALE_W-1:0];
                CFG_BLACK_OFFSET: r_black_offset <= i_cfg_wdata[OFFSET_W-1:0];
                CFG_BLACK_BASE:   r_black_base   <= i_cfg_wdata[BASE_W-1:0];
                default: ;
            endcase
        end
    end

    // Classify the key and form the press divisor t*256 + b
    always_comb begin
        n_black = BLACK_MAP[i_in_word.note_number];
        n_t     = i_in_word.tick_count & TICK_MASK;
        n_b     = n_black ? r_black_offset : r_white_offset;
        n_d     = $signed({2'b00, n_t, 8'h00}) + D_W'(n_b);
    end

    // Job word for the back part
    always_comb begin
        o_job.mode     = i_in_word.mode;
        o_job.is_black = n_black;
        o_job.a        = n_black ? r_black_scale : r_white_scale;
        o_job.c        = n_black ? r_black_base  : r_white_base;
        o_job.d        = n_d;
        o_job.t        = n_t;
        o_job.zero_div = (i_in_word.mode == MODE_RELEASE) ? (n_t == '0) : (n_d == '0);
    end

    assign o_in_stall = i_queue_full;
    assign o_job_push = i_in_valid && !i_queue_full;

endmodule

/* rtl/kvc_back.sv */
// Back part: numerator build, pipelined restoring divider and clamp.
`timescale 1ns / 1ps
module kvc_back #(
    parameter int MAX_VELOCITY = 127
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  kvc_pkg::t_job           i_job,
    input  logic                    i_job_valid,
    output logic                    o_job_pop,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output kvc_pkg::t_key_velocity  o_out_word
);
    import kvc_pkg::*;

    // Quotient bits needed to tell any value above MAX_VELOCITY
    localparam int QB = $clog2(MAX_VELOCITY + 1);

    logic en;

    // Stage 1: c*d product
    logic                       r1_vld;
    t_job                       r1_job;
    logic signed [PROD_W-1:0]   r1_prod;

    // Stage 2: signed numerator and divisor
    logic                       r2_vld, r2_black, r2_zero;
    logic signed [NUM_W-1:0]    r2_num;
    logic signed [DEN_W-1:0]    r2_den;
    logic signed [NUM_W-1:0]    n_num;
    logic signed [DEN_W-1:0]    n_den;

    // Stage 3: magnitudes and quotient sign
    logic                       r3_vld, r3_black, r3_zero, r3_neg;
    logic [NUM_W-1:0]           r3_nmag;
    logic [DEN_W-1:0]           r3_dmag;

    // Divider stages, index 0 holds the overflow check result
    logic                       r_dv_vld   [QB+1];
    logic [NUM_W-1:0]           r_dv_rem   [QB+1];
    logic [DEN_W-1:0]           r_dv_dmag  [QB+1];
    logic [QB-1:0]              r_dv_q     [QB+1];
    logic                       r_dv_neg   [QB+1];
    logic                       r_dv_ovf   [QB+1];
    logic                       r_dv_black [QB+1];
    logic                       r_dv_zero  [QB+1];

    logic [CMP_W-1:0]           n_shift    [QB];
    logic                       n_ge       [QB];
    logic [NUM_W-1:0]           n_rem      [QB];
    logic [QB-1:0]              n_q        [QB];
    logic                       n_ovf;

    // Output register
    logic                       r_out_valid;
    t_key_velocity              r_out_word;
    logic [15:0]                n_vel;
    logic                       n_clamped;

    // Whole pipeline moves unless a finished word is held
    assign en        = !(r_out_valid && i_out_stall);
    assign o_job_pop = i_job_valid && en;

    // Numerator and divisor: press 256a + c*d over 256d, release 3a over 512t
    always_comb begin
        if (r1_job.mode == MODE_RELEASE) begin
            n_num = NUM_W'(r1_job.a) + (NUM_W'(r1_job.a) <<< 1);
            n_den = DEN_W'($signed({1'b0, r1_job.t, 9'h000}));
        end else begin
            n_num = (NUM_W'(r1_job.a) <<< 8) + NUM_W'(r1_prod);
            n_den = DEN_W'(r1_job.d) <<< 8;
        end
    end

    // Quotient of 2^QB or more is out of range either way
    assign n_ovf = CMP_W'(r3_nmag) >= (CMP_W'(r3_dmag) << QB);

    // One quotient bit per stage
    always_comb begin
        for (int k = 0; k < QB; k++) begin
            n_shift[k] = CMP_W'(r_dv_dmag[k]) << (QB - 1 - k);
            n_ge[k]    = CMP_W'(r_dv_rem[k]) >= n_shift[k];
            n_rem[k]   = n_ge[k] ? NUM_W'(CMP_W'(r_dv_rem[k]) - n_shift[k]) : r_dv_rem[k];
            n_q[k]     = QB'({r_dv_q[k], n_ge[k]});
        end
    end

    // Clamp to 0..MAX_VELOCITY
    always_comb begin
        if (r_dv_zero[QB]) begin
            n_vel     = 16'(MAX_VELOCITY);
            n_clamped = 1'b1;
        end else if (r_dv_ovf[QB]) begin
            n_vel     = r_dv_neg[QB] ? 16'd0 : 16'(MAX_VELOCITY);
            n_clamped = 1'b1;
        end else if (r_dv_q[QB] == '0) begin
            n_vel     = 16'd0;
            n_clamped = 1'b0;
        end else if (r_dv_neg[QB]) begin
            n_vel     = 16'd0;
            n_clamped = 1'b1;
        end else if (16'(r_dv_q[QB]) > 16'(MAX_VELOCITY)) begin
            n_vel     = 16'(MAX_VELOCITY);
            n_clamped = 1'b1;
        end else begin
            n_vel     = 16'(r_dv_q[QB]);
            n_clamped = 1'b0;
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld      <= 1'b0;
            r2_vld      <= 1'b0;
            r3_vld      <= 1'b0;
            r_out_valid <= 1'b0;
            for (int k = 0; k <= QB; k++) r_dv_vld[k] <= 1'b0;
        end else if (en) begin
            r1_vld      <= i_job_valid;
            r2_vld      <= r1_vld;
            r3_vld      <= r2_vld;
            r_dv_vld[0] <= r3_vld;
            for (int k = 0; k < QB; k++) r_dv_vld[k+1] <= r_dv_vld[k];
            r_out_valid <= r_dv_vld[QB];
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_job   <= i_job;
            r1_prod  <= i_job.c * i_job.d;

            r2_num   <= n_num;
            r2_den   <= n_den;
            r2_black <= r1_job.is_black;
            r2_zero  <= r1_job.zero_div;

            r3_nmag  <= r2_num[NUM_W-1] ? NUM_W'(-r2_num) : NUM_W'(r2_num);
            r3_dmag  <= r2_den[DEN_W-1] ? DEN_W'(-r2_den) : DEN_W'(r2_den);
            r3_neg   <= r2_num[NUM_W-1] ^ r2_den[DEN_W-1];
            r3_black <= r2_black;
            r3_zero  <= r2_zero;

            r_dv_rem[0]   <= r3_nmag;
            r_dv_dmag[0]  <= r3_dmag;
            r_dv_q[0]     <= '0;
            r_dv_neg[0]   <= r3_neg;
            r_dv_ovf[0]   <= n_ovf;
            r_dv_black[0] <= r3_black;
            r_dv_zero[0]  <= r3_zero;
            for (int k = 0; k < QB; k++) begin
                r_dv_rem[k+1]   <= n_rem[k];
                r_dv_dmag[k+1]  <= r_dv_dmag[k];
                r_dv_q[k+1]     <= n_q[k];
                r_dv_neg[k+1]   <= r_dv_neg[k];
                r_dv_ovf[k+1]   <= r_dv_ovf[k];
                r_dv_black[k+1] <= r_dv_black[k];
                r_dv_zero[k+1]  <= r_dv_zero[k];
            end

            r_out_word.velocity <= n_vel[VEL_W-1:0];
            r_out_word.is_black <= r_dv_black[QB];
            r_out_word.clamped  <= n_clamped;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

/* dv/key_velocity_curve_unit_tb.sv */
// Self-checking testbench for the key velocity curve unit.
`timescale 1ns / 1ps
module key_velocity_curve_unit_tb;
    import kvc_pkg::*;

    localparam int VEL_MAX        = 127;
    localparam int DUT_LATENCY    = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_EVENTS   = 100;

    // Black keys within one octave, bit n set for pitch class n
    localparam int                  OCTAVE_KEYS      = 12;
    localparam logic [OCTAVE_KEYS-1:0] BLACK_KEY_OCTAVE = 12'b010101001010;

    // Register indexes past the last coefficient, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic          i_clk;
    logic          i_rst_n     = 1'b0;
    logic          i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    logic          i_in_valid  = 1'b0;
    logic          o_in_stall;
    t_key_event    i_in_word   = '0;
    logic          o_out_valid;
    logic          i_out_stall = 1'b0;
    t_key_velocity o_out_word;

    key_velocity_curve_unit #(
        .MAX_VELOCITY(VEL_MAX),
        .TICK_WIDTH  (TICK_W)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    // Shadow copy of the coefficients, index 0 white, 1 black
    logic signed [SCALE_W-1:0]  scale_q8  [2] = '{default: '0};
    logic signed [OFFSET_W-1:0] offset_q8 [2] = '{default: '0};
    logic signed [BASE_W-1:0]   base_q8   [2] = '{default: '0};

    t_key_event    key_events [$];
    t_key_velocity pending_velocities [$];
    t_key_velocity want_word;
    int            events_queued = 0;
    int            results_seen  = 0;
    int            err_count     = 0;
    int            idle_cycles   = 0;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;

    function automatic bit is_black_note(logic [NOTE_W-1:0] note);
        return BLACK_KEY_OCTAVE[note % OCTAVE_KEYS];
    endfunction

    // Velocity for one key event from the shadow coefficients, exact rational
    // math truncated toward zero, then clamped
    function automatic t_key_velocity predict_velocity(t_key_event ev);
        t_key_velocity res;
        bit     black;
        bit     div_zero;
        longint a, b, c, t, d, q;
        black    = is_black_note(ev.note_number);
        a        = scale_q8[black];
        b        = offset_q8[black];
        c        = base_q8[black];
        t        = ev.tick_count;
        div_zero = 1'b0;
        q        = 0;
        if (ev.mode == MODE_PRESS) begin
            d = t * 256 + b;
            if (d == 0) div_zero = 1'b1;
            else        q = (256 * a + c * d) / (256 * d);
        end else begin
            if (t == 0) div_zero = 1'b1;
            else        q = (3 * a) / (512 * t);
        end
        res.is_black = black;
        if (div_zero) begin
            res.velocity = VEL_W'(VEL_MAX);
            res.clamped  = 1'b1;
        end else if (q < 0) begin
            res.velocity = '0;
            res.clamped  = 1'b1;
        end else if (q > VEL_MAX) begin
            res.velocity = VEL_W'(VEL_MAX);
            res.clamped  = 1'b1;
        end else begin
            res.velocity = VEL_W'(q);
            res.clamped  = 1'b0;
        end
        return res;
    endfunction

    // Extreme or trivial value for a signed register of width w
    function automatic longint edge_value(int w);
        case ($urandom_range(0, 4))
            0:       return -(64'sd1 <<< (w - 1));
            1:       return (64'sd1 <<< (w - 1)) - 1;
            2:       return 0;
            3:       return -1;
            default: return longint'($urandom());
        endcase
    endfunction

    // Tick count: mostly playable range, some full range, some aimed at t+B = 0
    function automatic logic [TICK_W-1:0] pick_tick(bit black);
        longint center;
        longint cand;
        int     r;
        r = $urandom_range(0, 99);
        if (r < 10) return TICK_W'($urandom_range(0, 3));
        if (r < 50) return TICK_W'($urandom_range(0, 4095));
        if (r < 80) return TICK_W'($urandom());
        if (r < 92) begin
            center = offset_q8[black];
            center = -center / 256;
            cand   = center + longint'($urandom_range(0, 4)) - 2;
            if (cand >= 0 && cand < (64'sd1 <<< TICK_W)) return TICK_W'(cand);
            return TICK_W'($urandom());
        end
        return TICK_W'($urandom_range(65532, 65535));
    endfunction

    task automatic add_event(logic mode, logic [NOTE_W-1:0] note, logic [TICK_W-1:0] tick);
        t_key_event ev;
        ev.mode        = mode;
        ev.note_number = note;
        ev.tick_count  = tick;
        key_events.push_back(ev);
        events_queued++;
    endtask

    // One register write, shadow copy updated alongside
    task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        case (idx)
            CFG_WHITE_SCALE:  scale_q8[0]  = data[SCALE_W-1:0];
            CFG_WHITE_OFFSET: offset_q8[0] = data[OFFSET_W-1:0];
            CFG_WHITE_BASE:   base_q8[0]   = data[BASE_W-1:0];
            CFG_BLACK_SCALE:  scale_q8[1]  = data[SCALE_W-1:0];
            CFG_BLACK_OFFSET: offset_q8[1] = data[OFFSET_W-1:0];
            CFG_BLACK_BASE:   base_q8[1]   = data[BASE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_curve(bit black, logic [CFG_W-1:0] a, logic [CFG_W-1:0] b,
                             logic [CFG_W-1:0] c);
        write_coef(black ? CFG_BLACK_SCALE  : CFG_WHITE_SCALE,  a);
        write_coef(black ? CFG_BLACK_OFFSET : CFG_WHITE_OFFSET, b);
        write_coef(black ? CFG_BLACK_BASE   : CFG_WHITE_BASE,   c);
    endtask

    // Random curve: raw bits, a playable curve, or extremes
    task automatic random_curve(bit black);
        longint a, b, c;
        case ($urandom_range(0, 2))
            0: begin
                a = $urandom();
                b = $urandom();
                c = $urandom();
            end
            1: begin
                a = longint'($urandom_range(1000, 400000)) * 256
                    + (($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 255));
                if ($urandom_range(0, 4) == 0) a = -a;
                b = (longint'($urandom_range(0, 300)) - 50) * 256
                    + (($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 255));
                c = (longint'($urandom_range(0, 40)) - 20) * 256
                    + (($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 255));
            end
            default: begin
                a = edge_value(SCALE_W);
                b = edge_value(OFFSET_W);
                c = edge_value(BASE_W);
            end
        endcase
        set_curve(black, CFG_W'(a), CFG_W'(b), CFG_W'(c));
    endtask

    // Block until every queued word has produced its result
    task automatic wait_drained();
        while (results_seen < events_queued) @(posedge i_clk);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Input driver: payload held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || !o_in_stall) begin
            if (key_events.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in_word  <= key_events.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Output back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // Result check first, then prediction for the word accepted on this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                results_seen++;
                if (pending_velocities.size() == 0) begin
                    $error("result word with none pending: %p", o_out_word);
                    err_count++;
                end else begin
                    want_word = pending_velocities.pop_front();
                    if (o_out_word.velocity !== want_word.velocity) begin
                        $error("velocity: expected %0d, actual %0d",
                               want_word.velocity, o_out_word.velocity);
                        err_count++;
                    end
                    if (o_out_word.is_black !== want_word.is_black) begin
                        $error("is_black: expected %0b, actual %0b",
                               want_word.is_black, o_out_word.is_black);
                        err_count++;
                    end
                    if (o_out_word.clamped !== want_word.clamped) begin
                        $error("clamped: expected %0b, actual %0b",
                               want_word.clamped, o_out_word.clamped);
                        err_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                pending_velocities.push_back(predict_velocity(i_in_word));
            end
        end
    end

    // Watchdog on cycles with no traffic at all
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid === 1'b1 && !i_out_stall)
                || i_cfg_wr_en) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // All coefficients zero: divide by zero on both modes gives full velocity, others zero
        add_event(MODE_PRESS,   7'd0,   16'd0);
        add_event(MODE_RELEASE, 7'd1,   16'd0);
        add_event(MODE_PRESS,   7'd127, 16'hFFFF);
        add_event(MODE_RELEASE, 7'd127, 16'hFFFF);
        add_event(MODE_RELEASE, 7'd0,   16'd1);
        wait_drained();

        // Playable white curve; black curve gives tiny negative results
        send_idle_pct = 60;
        set_curve(1'b0, 32'sd25600000, 32'sd12800, -32'sd1280);
        set_curve(1'b1, -32'sd256, 32'sd0, 32'sd0);
        add_event(MODE_PRESS,   7'd60, 16'd0);
        add_event(MODE_PRESS,   7'd62, 16'd1000);
        add_event(MODE_PRESS,   7'd64, 16'hFFFF);
        add_event(MODE_RELEASE, 7'd65, 16'd2000);
        add_event(MODE_RELEASE, 7'd67, 16'hFFFF);
        add_event(MODE_PRESS,   7'd61, 16'd10);
        add_event(MODE_RELEASE, 7'd63, 16'd1);
        add_event(MODE_RELEASE, 7'd66, 16'd40);
        wait_drained();

        // Register extremes, plus writes to the unused indexes that must not land
        send_idle_pct  = 0;
        recv_stall_pct = 60;
        set_curve(1'b0, 32'h7FFF_FFFF, 32'h0080_0000, 32'h0000_8000);
        set_curve(1'b1, 32'h8000_0000, 32'h007F_FFFF, 32'h0000_7FFF);
        write_coef(CFG_SPARE_LO, '0);
        write_coef(CFG_SPARE_HI, $urandom());
        add_event(MODE_PRESS,   7'd69,  16'd32768);
        add_event(MODE_PRESS,   7'd71,  16'd32767);
        add_event(MODE_PRESS,   7'd72,  16'd32769);
        add_event(MODE_PRESS,   7'd48,  16'd0);
        add_event(MODE_RELEASE, 7'd127, 16'd1);
        add_event(MODE_PRESS,   7'd70,  16'd0);
        add_event(MODE_PRESS,   7'd68,  16'hFFFF);
        add_event(MODE_RELEASE, 7'd73,  16'd1);
        add_event(MODE_RELEASE, 7'd75,  16'hFFFF);
        wait_drained();

        // Random phases: new curves each time, rotating idle patterns
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 5)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                3: begin send_idle_pct = 6;  recv_stall_pct = 6;  end
                default: begin send_idle_pct = 60; recv_stall_pct = 60; end
            endcase
            random_curve(1'b0);
            random_curve(1'b1);
            if ($urandom_range(0, 2) == 0)
                write_coef(($urandom_range(0, 1) != 0) ? CFG_SPARE_HI : CFG_SPARE_LO,
                           $urandom());
            for (int i = 0; i < PHASE_EVENTS; i++) begin
                logic [NOTE_W-1:0] note;
                note = NOTE_W'($urandom_range(0, 127));
                add_event(($urandom_range(0, 1) != 0) ? MODE_RELEASE : MODE_PRESS,
                          note, pick_tick(is_black_note(note)));
            end
            wait_drained();
        end

        repeat (DUT_LATENCY + 8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
